FILE: sv/scrb_pkg.sv
package scrb_pkg;

  // Build-time sizing
  localparam int NUM_RINGS      = 4;
  localparam int SLOTS_PER_RING = 64;
  localparam int HEADER_BYTES   = 16;

  localparam int TOTAL_SLOTS = NUM_RINGS * SLOTS_PER_RING;
  localparam int RING_W      = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int SLOT_W      = $clog2(SLOTS_PER_RING);
  localparam int IDX_W       = $clog2(TOTAL_SLOTS);
  // Scan position runs 0..4: at most four size registers exist
  localparam int SCAN_W      = 3;
  localparam int SIZE_REGS   = 4;

  // Request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // Result status codes
  localparam logic [2:0] STAT_GRANT     = 3'd0;
  localparam logic [2:0] STAT_FALLBACK  = 3'd1;
  localparam logic [2:0] STAT_RING_FREE = 3'd2;
  localparam logic [2:0] STAT_HEAP_FREE = 3'd3;
  localparam logic [2:0] STAT_COUNTER   = 3'd4;

  // Counter select codes
  localparam logic [3:0] SEL_MISS_BASE = 4'd4;
  localparam logic [3:0] SEL_RECLAIM   = 4'd8;
  localparam logic [3:0] SEL_FALLBACK  = 4'd9;

  // Configuration register indexes
  localparam logic [2:0] CFG_SIZE0   = 3'd0;
  localparam logic [2:0] CFG_SIZE1   = 3'd1;
  localparam logic [2:0] CFG_SIZE2   = 3'd2;
  localparam logic [2:0] CFG_SIZE3   = 3'd3;
  localparam logic [2:0] CFG_RINGS   = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT = 3'd5;

  localparam logic [15:0] RST_SIZE0   = 16'd64;
  localparam logic [15:0] RST_SIZE1   = 16'd256;
  localparam logic [15:0] RST_SIZE2   = 16'd1024;
  localparam logic [15:0] RST_SIZE3   = 16'd4096;
  localparam logic [2:0]  RST_RINGS   = 3'd4;
  localparam logic [7:0]  RST_TIMEOUT = 8'd10;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] request_bytes;
    logic [31:0] now_seconds;
    logic        buffer_from_ring;
    logic [1:0]  free_ring;
    logic [5:0]  free_slot;
    logic [3:0]  counter_select;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  granted_ring;
    logic [5:0]  granted_slot;
    logic        was_reclaimed;
    logic [15:0] payload_length;
    logic [31:0] counter_value;
  } out_word_t;

  // One slot's bookkeeping as held in the slot RAM
  typedef struct packed {
    logic        busy;
    logic        marked;
    logic [31:0] stamp;
  } slot_ent_t;

  typedef struct packed {
    logic       accept;
    logic       scan_next;
    logic       rd_en;
    logic       grant;
    logic       mark;
    logic       miss;
    logic       fallback;
    logic       free_wr;
    logic       load_out;
    logic [2:0] out_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] new_req;
    logic       ring_done;
    logic       ring_fits;
    logic       slot_busy;
    logic       slot_marked;
    logic       expired;
    logic       out_free;
    logic       from_ring;
    logic       free_in_range;
  } sts_t;

endpackage

FILE: sv/size_class_ring_buffer_allocator_core.sv
// Size-class ring allocator: each word on the input channel is an allocate, a free or a
// counter read, and every request except the unused code 3 returns exactly one result word.
// An allocate scans the rings lowest first, one ring at a time through a shared slot RAM
// with a registered read: a ring too small for the request plus header is skipped in the
// scan state, and a ring whose head slot is read passes through the scan and read states.
// An allocate granted on ring 0 passes through accept, scan and decide; one that no ring
// grants ends in a fallback result. A free or a counter read is accepted, then answered. The
// result sits in an output register, so the next request is taken while the previous result
// still waits; the block holds off finishing only while that register is still full and
// stalled. Slot state comes up free after reset with no clearing pass: a per-slot valid bit
// marks written entries. Configuration writes are always ready and must only be issued while idle.
module size_class_ring_buffer_allocator_core
  import scrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Config writes are registered directly; nothing to wait on
  assign cfg_ready = 1'b1;

  // Sequencer: steps the ring scan, decides grant, mark, miss or fallback, and answers frees and counter reads
  scrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: request register, head pointers, slot RAM, counters, result word
  scrb_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: sv/scrb_ram.sv
module scrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/scrb_ctrl.sv
module scrb_ctrl
  import scrb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_FREE = 3'd3;
  localparam logic [2:0] S_CNT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    cmd.out_sel = STAT_GRANT;
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (sts.new_req)
            REQ_ALLOC: state_nxt = S_SCAN;
            REQ_FREE:  state_nxt = S_FREE;
            REQ_READ:  state_nxt = S_CNT;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.ring_done) begin
          if (sts.out_free) begin
            cmd.fallback = 1'b1;
            cmd.load_out = 1'b1;
            cmd.out_sel  = STAT_FALLBACK;
            state_nxt    = S_IDLE;
          end
        end else if (!sts.ring_fits) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (!sts.slot_busy || (sts.slot_marked && sts.expired)) begin
          // hold the read word until the result register frees up
          if (sts.out_free) begin
            cmd.grant    = 1'b1;
            cmd.load_out = 1'b1;
            cmd.out_sel  = STAT_GRANT;
            state_nxt    = S_IDLE;
          end
        end else if (!sts.slot_marked) begin
          cmd.mark      = 1'b1;
          cmd.scan_next = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.miss      = 1'b1;
          cmd.scan_next = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_FREE: begin
        if (sts.out_free) begin
          cmd.free_wr  = sts.from_ring && sts.free_in_range;
          cmd.load_out = 1'b1;
          cmd.out_sel  = sts.from_ring ? STAT_RING_FREE : STAT_HEAP_FREE;
          state_nxt    = S_IDLE;
        end
      end
      S_CNT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = STAT_COUNTER;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending word");

  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.grant, cmd.mark, cmd.miss, cmd.fallback, cmd.free_wr}))
    else $error("more than one slot update in a cycle");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> state_r == S_READ)
    else $error("slot read not followed by decision");

  a_grant_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |-> (state_r == S_READ) && !sts.ring_done)
    else $error("grant outside a live ring visit");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && (sts.new_req != REQ_NONE) |=> state_r != S_IDLE)
    else $error("accepted request dropped");
`endif

endmodule

FILE: sv/scrb_dpath.sv
module scrb_dpath
  import scrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts
);

  in_word_t           in_r;
  logic [15:0]        class_size_r [SIZE_REGS];
  logic [2:0]         rings_r;
  logic [7:0]         timeout_r;
  logic [SCAN_W-1:0]  scan_r;
  logic [SLOT_W-1:0]  head_r [NUM_RINGS];
  logic [31:0]        hit_r [NUM_RINGS];
  logic [31:0]        miss_r [NUM_RINGS];
  logic [31:0]        reclaim_r;
  logic [31:0]        fallback_r;
  logic [TOTAL_SLOTS-1:0] vld_r;
  logic               rd_vld_r;
  logic               out_valid_r;
  out_word_t          out_r;
  out_word_t          out_nxt;

  logic [SCAN_W-1:0]  lim;
  logic [16:0]        need;
  logic [RING_W-1:0]  cur_ring;
  logic [SLOT_W-1:0]  cur_head;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   free_idx;
  logic               free_in_range;
  slot_ent_t          rd_ent;
  slot_ent_t          ent;
  slot_ent_t          wr_ent;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [31:0]        elapsed;
  logic [31:0]        cnt_val;
  logic               out_free;

  // Search limit: register value clipped to the ring count and size registers
  always_comb begin
    lim = rings_r;
    if (int'(rings_r) > NUM_RINGS) begin
      lim = SCAN_W'(NUM_RINGS);
    end
    if (lim > SCAN_W'(SIZE_REGS)) begin
      lim = SCAN_W'(SIZE_REGS);
    end
  end

  assign need     = {1'b0, in_r.request_bytes} + 17'(HEADER_BYTES);
  assign cur_ring = RING_W'(scan_r);
  assign cur_head = head_r[cur_ring];
  assign scan_idx = IDX_W'(cur_ring) * IDX_W'(SLOTS_PER_RING) + IDX_W'(cur_head);

  assign free_in_range = (int'(in_r.free_ring) < NUM_RINGS) &&
                         (int'(in_r.free_slot) < SLOTS_PER_RING);
  assign free_idx = IDX_W'(in_r.free_ring) * IDX_W'(SLOTS_PER_RING) +
                    IDX_W'(in_r.free_slot);

  // Never-written slots read as free and unmarked
  assign ent     = rd_vld_r ? rd_ent : '0;
  assign elapsed = in_r.now_seconds - ent.stamp;

  always_comb begin
    wr_en   = cmd.grant || cmd.mark || cmd.free_wr;
    wr_addr = cmd.free_wr ? free_idx : scan_idx;
    wr_ent  = '0;
    if (cmd.mark) begin
      wr_ent.busy   = 1'b1;
      wr_ent.marked = 1'b1;
      wr_ent.stamp  = in_r.now_seconds;
    end else if (cmd.grant) begin
      wr_ent.busy = 1'b1;
    end
  end

  scrb_ram #(
    .WIDTH ($bits(slot_ent_t)),
    .DEPTH (TOTAL_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (cmd.rd_en),
    .rd_addr (scan_idx),
    .rd_data (rd_ent)
  );

  always_comb begin
    cnt_val = '0;
    if (in_r.counter_select < SEL_MISS_BASE) begin
      if (int'(in_r.counter_select) < NUM_RINGS) begin
        cnt_val = hit_r[RING_W'(in_r.counter_select)];
      end
    end else if (in_r.counter_select < SEL_RECLAIM) begin
      if (int'(in_r.counter_select - SEL_MISS_BASE) < NUM_RINGS) begin
        cnt_val = miss_r[RING_W'(in_r.counter_select - SEL_MISS_BASE)];
      end
    end else if (in_r.counter_select == SEL_RECLAIM) begin
      cnt_val = reclaim_r;
    end else if (in_r.counter_select == SEL_FALLBACK) begin
      cnt_val = fallback_r;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts               = '0;
    sts.new_req       = in_word.req_type;
    sts.ring_done     = scan_r >= lim;
    sts.ring_fits     = need <= {1'b0, class_size_r[scan_r[1:0]]};
    sts.slot_busy     = ent.busy;
    sts.slot_marked   = ent.marked;
    sts.expired       = elapsed > {24'd0, timeout_r};
    sts.out_free      = out_free;
    sts.from_ring     = in_r.buffer_from_ring;
    sts.free_in_range = free_in_range;
  end

  // Result word assembled from the current decision
  always_comb begin
    out_nxt        = '0;
    out_nxt.status = cmd.out_sel;
    case (cmd.out_sel)
      STAT_GRANT: begin
        out_nxt.granted_ring   = 2'(cur_ring);
        out_nxt.granted_slot   = 6'(cur_head);
        out_nxt.was_reclaimed  = ent.busy;
        out_nxt.payload_length = in_r.request_bytes;
      end
      STAT_FALLBACK: begin
        out_nxt.payload_length = in_r.request_bytes;
      end
      STAT_COUNTER: begin
        out_nxt.counter_value = cnt_val;
      end
      default: begin
      end
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r <= in_word;
    end
    if (cmd.rd_en) begin
      rd_vld_r <= vld_r[scan_idx];
    end
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  // Control state, configuration and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_size_r[0] <= RST_SIZE0;
      class_size_r[1] <= RST_SIZE1;
      class_size_r[2] <= RST_SIZE2;
      class_size_r[3] <= RST_SIZE3;
      rings_r     <= RST_RINGS;
      timeout_r   <= RST_TIMEOUT;
      scan_r      <= '0;
      reclaim_r   <= '0;
      fallback_r  <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_RINGS; i++) begin
        head_r[i] <= '0;
        hit_r[i]  <= '0;
        miss_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SIZE0:   class_size_r[0] <= cfg_data;
          CFG_SIZE1:   class_size_r[1] <= cfg_data;
          CFG_SIZE2:   class_size_r[2] <= cfg_data;
          CFG_SIZE3:   class_size_r[3] <= cfg_data;
          CFG_RINGS:   rings_r         <= cfg_data[2:0];
          CFG_TIMEOUT: timeout_r       <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        scan_r <= '0;
      end else if (cmd.scan_next) begin
        scan_r <= scan_r + 1'b1;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.grant) begin
        hit_r[cur_ring] <= hit_r[cur_ring] + 32'd1;
        if (int'(cur_head) == SLOTS_PER_RING - 1) begin
          head_r[cur_ring] <= '0;
        end else begin
          head_r[cur_ring] <= cur_head + 1'b1;
        end
        if (ent.busy) begin
          reclaim_r <= reclaim_r + 32'd1;
        end
      end
      if (cmd.mark || cmd.miss) begin
        miss_r[cur_ring] <= miss_r[cur_ring] + 32'd1;
      end
      if (cmd.fallback) begin
        fallback_r <= fallback_r + 32'd1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
